// ===== design/dsg_pkg.sv =====
// ----------------------------------------------------------------------------
// dsg_pkg: shared types and constants of the diagnostic session gate
// service codes, session codes, error kinds and the transaction payloads
// ----------------------------------------------------------------------------
package dsg_pkg;

  // service identifiers
  localparam logic [7:0] SidSessionCtrl = 8'h10;
  localparam logic [7:0] SidEcuReset    = 8'h11;
  localparam logic [7:0] SidReadDid     = 8'h22;
  localparam logic [7:0] SidSecAccess   = 8'h27;
  localparam logic [7:0] SidWriteDid    = 8'h2E;
  localparam logic [7:0] SidRoutine     = 8'h31;
  localparam logic [7:0] SidTester      = 8'h3E;
  localparam logic [7:0] PosOffset      = 8'h40;
  localparam logic [7:0] NegSid         = 8'h7F;

  localparam logic [31:0] SeedFallback  = 32'h1234_5678;
  localparam logic [31:0] MaskReset     = 32'hABCD_EF00;
  localparam logic [15:0] DidStartReset = 16'hF1A0;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgKeyXorMask   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgProtDidStart = 8'd1;

  typedef enum logic [1:0] {
    SESS_DEFAULT  = 2'd1,
    SESS_PROGRAM  = 2'd2,
    SESS_EXTENDED = 2'd3
  } sess_e;

  typedef enum logic [2:0] {
    EK_NONE    = 3'd0,
    EK_SERVICE = 3'd1,
    EK_SUBFUNC = 3'd2,
    EK_LENGTH  = 3'd3,
    EK_RANGE   = 3'd4,
    EK_DENIED  = 3'd5,
    EK_KEY     = 3'd6,
    EK_SESSION = 3'd7
  } err_kind_e;

  typedef struct packed {
    logic [7:0]  service_id;
    logic [7:0]  sub_function;
    logic [2:0]  payload_len;
    logic [31:0] payload_word;
    logic        did_known;
    logic [31:0] random_value;
    logic [31:0] time_ms;
  } req_t;

  typedef struct packed {
    logic [7:0]  response_sid;
    logic [7:0]  echo_byte;
    logic        is_negative;
    err_kind_e   error_kind;
    logic [31:0] resp_word;
    logic [2:0]  resp_len;
    logic        read_granted;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        wdata;
  } cfg_t;

endpackage

// ===== design/dsg_if.sv =====
// ----------------------------------------------------------------------------
// dsg channel interfaces
// valid/ready channels for requests, responses and configuration writes
// ----------------------------------------------------------------------------
interface dsg_req_if import dsg_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dsg_rsp_if import dsg_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dsg_cfg_if import dsg_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/diag_session_security_gate_top.sv =====
// ----------------------------------------------------------------------------
// diag_session_security_gate_top: diagnostic session and security access gate
// timing: the response is registered, valid in the cycle after acceptance
// throughput: one request per cycle while responses are taken downstream;
// the response register is the only stage, refilled in the cycle it is taken
// reset: rst_ni async low; default session, not authenticated, seed zero,
// mask and protected DID start at their reset values, no response pending
// ----------------------------------------------------------------------------
module diag_session_security_gate_top
  import dsg_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  dsg_req_if.sink       req,
  dsg_rsp_if.source     rsp,
  dsg_cfg_if.sink       cfg
);

  // configuration registers
  logic [31:0] key_mask_q;
  logic [15:0] did_start_q;

  // session state
  sess_e       session_q, session_d;
  logic        auth_q, auth_d;
  logic [7:0]  sec_level_q, sec_level_d;
  logic [31:0] seed_q, seed_d;

  // response register
  logic        rsp_valid_q;
  rsp_t        rsp_q, rsp_d;

  logic        req_fire;
  logic        cfg_fire;

  // request fields
  logic [7:0]  sid;
  logic [7:0]  sub;
  logic [15:0] did;
  logic [31:0] new_seed;
  logic        sess_gate;

  // response stage is free when empty or being drained this cycle
  assign req.ready = !rsp_valid_q || rsp.ready;
  assign req_fire  = req.valid && req.ready;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;

  assign sid      = req.data.service_id;
  assign sub      = req.data.sub_function;
  assign did      = req.data.payload_word[15:0];
  assign new_seed = (req.data.random_value == 32'd0) ? SeedFallback
                                                      : req.data.random_value;

  // read, write and routine are refused in the default session
  assign sess_gate = (session_q == SESS_DEFAULT) &&
                     (sid == SidReadDid || sid == SidWriteDid || sid == SidRoutine);

  // ---------------------------------------------------------------------
  // request decode: response and next state in one pass
  // ---------------------------------------------------------------------
  always_comb begin
    session_d   = session_q;
    auth_d      = auth_q;
    sec_level_d = sec_level_q;
    seed_d      = seed_q;

    // default to a negative answer; positive paths overwrite it
    rsp_d.response_sid = NegSid;
    rsp_d.echo_byte    = sid;
    rsp_d.is_negative  = 1'b1;
    rsp_d.error_kind   = EK_SERVICE;
    rsp_d.resp_word    = 32'd0;
    rsp_d.resp_len     = 3'd0;
    rsp_d.read_granted = 1'b0;

    if (sess_gate) begin
      rsp_d.error_kind = EK_SESSION;
    end else begin
      case (sid)
        SidSessionCtrl: begin
          if (sub == 8'(SESS_DEFAULT)) begin
            session_d   = SESS_DEFAULT;
            auth_d      = 1'b0;
            sec_level_d = 8'd0;
            rsp_d.is_negative = 1'b0;
          end else if (sub == 8'(SESS_PROGRAM) || sub == 8'(SESS_EXTENDED)) begin
            if (!auth_q) begin
              rsp_d.error_kind = EK_DENIED;
            end else begin
              session_d = sess_e'(sub[1:0]);
              rsp_d.is_negative = 1'b0;
            end
          end else begin
            rsp_d.error_kind = EK_SUBFUNC;
          end
          if (!rsp_d.is_negative) begin
            // echo the sub-function as a single response byte
            rsp_d.echo_byte = sub;
            rsp_d.resp_len  = 3'd1;
          end
        end

        SidReadDid: begin
          if (req.data.payload_len < 3'd2) begin
            rsp_d.error_kind = EK_LENGTH;
          end else if (!req.data.did_known) begin
            rsp_d.error_kind = EK_RANGE;
          end else if (did >= did_start_q && !auth_q) begin
            rsp_d.error_kind = EK_DENIED;
          end else begin
            // data bytes are appended from the external identifier store
            rsp_d.is_negative  = 1'b0;
            rsp_d.echo_byte    = 8'd0;
            rsp_d.resp_word    = {16'd0, did};
            rsp_d.resp_len     = 3'd2;
            rsp_d.read_granted = 1'b1;
          end
        end

        SidTester: begin
          if (sub != 8'd0) begin
            rsp_d.error_kind = EK_SUBFUNC;
          end else begin
            rsp_d.is_negative = 1'b0;
            rsp_d.echo_byte   = 8'd0;
          end
        end

        SidSecAccess: begin
          if (sub[0]) begin
            // seed request: level follows the sub-function pair
            seed_d      = new_seed;
            sec_level_d = {1'b0, sub[7:1]} + 8'd1;
            rsp_d.is_negative = 1'b0;
            rsp_d.echo_byte   = sub;
            rsp_d.resp_word   = new_seed;
            rsp_d.resp_len    = 3'd4;
          end else if (req.data.payload_len < 3'd4) begin
            rsp_d.error_kind = EK_LENGTH;
          end else if (req.data.payload_word != (seed_q ^ key_mask_q)) begin
            rsp_d.error_kind = EK_KEY;
          end else begin
            auth_d = 1'b1;
            rsp_d.is_negative = 1'b0;
            rsp_d.echo_byte   = sub;
          end
        end

        SidEcuReset: begin
          if (sub inside {[8'd1:8'd3]}) begin
            // reset time is echoed back
            rsp_d.is_negative = 1'b0;
            rsp_d.echo_byte   = sub;
            rsp_d.resp_word   = req.data.time_ms;
            rsp_d.resp_len    = 3'd4;
          end else begin
            rsp_d.error_kind = EK_SUBFUNC;
          end
        end

        default: begin
          rsp_d.error_kind = EK_SERVICE;
        end
      endcase
    end

    if (!rsp_d.is_negative) begin
      rsp_d.response_sid = sid + PosOffset;
      rsp_d.error_kind   = EK_NONE;
    end
  end

  // ---------------------------------------------------------------------
  // configuration registers; out-of-range indexes are dropped
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_mask_q  <= MaskReset;
      did_start_q <= DidStartReset;
    end else if (cfg_fire) begin
      if (cfg.data.index == CfgKeyXorMask) begin
        key_mask_q <= cfg.data.wdata;
      end else if (cfg.data.index == CfgProtDidStart) begin
        did_start_q <= cfg.data.wdata[15:0];
      end
    end
  end

  // session state only moves on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q   <= SESS_DEFAULT;
      auth_q      <= 1'b0;
      sec_level_q <= 8'd0;
      seed_q      <= 32'd0;
    end else if (req_fire) begin
      session_q   <= session_d;
      auth_q      <= auth_d;
      sec_level_q <= sec_level_d;
      seed_q      <= seed_d;
    end
  end

  // response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // response payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_neg_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.is_negative) |->
      (rsp_q.resp_word == 32'd0 && rsp_q.resp_len == 3'd0 && !rsp_q.read_granted))
    else $error("negative response carries data");

  a_grant_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.read_granted) |->
      (rsp_q.response_sid == (SidReadDid + PosOffset) && rsp_q.resp_len == 3'd2))
    else $error("read grant on a non-read response");

  a_sess_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    session_q != sess_e'(2'd0))
    else $error("session register holds an unused code");

  a_default_drops_auth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && sid == SidSessionCtrl && sub == 8'(SESS_DEFAULT)) |=>
      (!auth_q && sec_level_q == 8'd0 && session_q == SESS_DEFAULT))
    else $error("default session request left authentication set");

  a_kind_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_q.is_negative == (rsp_q.error_kind != EK_NONE)))
    else $error("error kind disagrees with response sign");

endmodule
